// ===== rtl/core/dzs_pkg.sv =====
// Package for the diagonal zigzag scan block.
// Holds sizes, register indexes, the sequencer state type and status struct.
// Used by dzs_scan_seq and diagonal_zigzag_scan.
package dzs_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int DATA_W   = 32;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LC_W     = $clog2(STORE_DEPTH + 1);
  localparam int DIM_R_W  = $clog2(MAX_ROWS + 1);
  localparam int DIM_C_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int K_W      = (MAX_ROWS + MAX_COLS - 1 > 1) ?
                            $clog2(MAX_ROWS + MAX_COLS - 1) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = CFG_W'(8);
  localparam logic [CFG_W-1:0] COL_COUNT_RST = CFG_W'(8);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic last;
  } seq_stat_t;

endpackage

// ===== rtl/core/dzs_scan_seq.sv =====
// Zigzag address sequencer: walks the diagonals and yields store addresses.
// One address per step; flags the final element of the scan.
// Depends on dzs_pkg.
module dzs_scan_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [dzs_pkg::DIM_R_W-1:0] rows_i,
  input  logic [dzs_pkg::DIM_C_W-1:0] cols_i,
  output logic [dzs_pkg::ADDR_W-1:0]  addr_o,
  output dzs_pkg::seq_stat_t          stat_o
);
  import dzs_pkg::*;

  localparam int CW = K_W + DIM_R_W + DIM_C_W;
  localparam int PW = ROW_W + DIM_C_W + 1;

  seq_state_e        state_q, state_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [ROW_W-1:0]  i_q, i_d;
  logic [COL_W-1:0]  j_q, j_d;

  logic [CW-1:0]     kn, rm1, cm1, kmax, si, sj;
  logic              up, eod, last;
  logic [PW-1:0]     addr_w;

  assign rm1  = CW'(rows_i) - CW'(1);
  assign cm1  = CW'(cols_i) - CW'(1);
  assign kmax = rm1 + cm1;
  assign kn   = CW'(k_q) + CW'(1);
  assign up   = ~k_q[0];
  assign eod  = up ? ((i_q == '0) || (j_q == '0))
                   : ((CW'(i_q) == rm1) || (CW'(j_q) == cm1));
  assign last = (CW'(k_q) == kmax) && eod;

  assign addr_w = PW'(i_q) * PW'(cols_i) + PW'(j_q);
  assign addr_o = addr_w[ADDR_W-1:0];

  // start of the next diagonal
  always_comb begin
    if (!kn[0]) begin
      if (kn <= rm1) begin
        si = kn;
        sj = cm1;
      end else begin
        si = rm1;
        sj = kmax - kn;
      end
    end else begin
      if (kn <= cm1) begin
        si = '0;
        sj = cm1 - kn;
      end else begin
        si = kn - cm1;
        sj = '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SCAN;
      ST_SCAN: if (step_i && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy = (state_q == ST_SCAN);
    stat_o.last = last;
  end

  always_comb begin
    k_d = k_q;
    i_d = i_q;
    j_d = j_q;
    if (start_i && state_q == ST_IDLE) begin
      k_d = '0;
      i_d = '0;
      j_d = cm1[COL_W-1:0];
    end else if (step_i && state_q == ST_SCAN) begin
      if (eod) begin
        k_d = kn[K_W-1:0];
        i_d = si[ROW_W-1:0];
        j_d = sj[COL_W-1:0];
      end else if (up) begin
        i_d = i_q - ROW_W'(1);
        j_d = j_q - COL_W'(1);
      end else begin
        i_d = i_q + ROW_W'(1);
        j_d = j_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

endmodule

// ===== rtl/core/diagonal_zigzag_scan.sv =====
// Diagonal zigzag scan: loads a matrix row-major, emits it in zigzag order.
// The completing element's transfer starts the scan state; results then leave through the registered read data.
// Throughput: one load per cycle while no scan is busy, one result per cycle while out_ready_i holds;
// the store's single read port with registered data sets the emit rate.
// Reset clears the load count and scan state; dimensions return to 8 by 8; store is not cleared.
// Depends on dzs_pkg and dzs_scan_seq.
module diagonal_zigzag_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dzs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dzs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [dzs_pkg::DATA_W-1:0] element_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [dzs_pkg::DATA_W-1:0] value_o,
  output logic                          last_o
);
  import dzs_pkg::*;

  localparam int TOT_W = DIM_R_W + DIM_C_W;
  localparam int CMP_W = TOT_W + LC_W;

  logic [CFG_W-1:0]   row_count_q, col_count_q;
  logic [DIM_R_W-1:0] rows;
  logic [DIM_C_W-1:0] cols;
  logic [TOT_W-1:0]   total;
  logic [LC_W-1:0]    lc_q, lc_d, lc_inc;
  logic               in_fire, done, issue;
  logic               out_valid_q, last_q;
  logic [DATA_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0]  rd_addr;
  seq_stat_t          stat;

  logic [DATA_W-1:0]  mem [STORE_DEPTH];

  always_comb begin
    if (row_count_q == '0) rows = DIM_R_W'(1);
    else if (32'(row_count_q) > 32'(MAX_ROWS)) rows = DIM_R_W'(MAX_ROWS);
    else rows = DIM_R_W'(row_count_q);
    if (col_count_q == '0) cols = DIM_C_W'(1);
    else if (32'(col_count_q) > 32'(MAX_COLS)) cols = DIM_C_W'(MAX_COLS);
    else cols = DIM_C_W'(col_count_q);
  end

  assign total  = TOT_W'(rows) * TOT_W'(cols);
  assign lc_inc = lc_q + LC_W'(1);
  assign done   = CMP_W'(lc_inc) >= CMP_W'(total);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~stat.busy;
  assign in_fire     = in_valid_i & in_ready_o;
  assign issue       = stat.busy & (~out_valid_q | out_ready_i);

  always_comb begin
    lc_d = lc_q;
    if (in_fire) lc_d = done ? '0 : lc_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROW_COUNT: row_count_q <= cfg_data_i;
        REG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q        <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      lc_q <= lc_d;
      if (issue) begin
        out_valid_q <= 1'b1;
        last_q      <= stat.last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (32'(lc_q) < 32'(STORE_DEPTH))) begin
      mem[lc_q[ADDR_W-1:0]] <= element_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  dzs_scan_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire & done),
    .step_i (issue),
    .rows_i (rows),
    .cols_i (cols),
    .addr_o (rd_addr),
    .stat_o (stat)
  );

  assign out_valid_o = out_valid_q;
  assign value_o     = rd_data_q;
  assign last_o      = last_q;

endmodule
